// File: rtl/core/sct_pkg.sv
package sct_pkg;

  localparam int TOKW = 21;
  localparam int VALW = 63;
  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);
  localparam int QCW = $clog2(QDEPTH + 1);

  localparam logic [3:0] K_EOF    = 4'd0;
  localparam logic [3:0] K_NL     = 4'd1;
  localparam logic [3:0] K_IDENT  = 4'd2;
  localparam logic [3:0] K_INT    = 4'd3;
  localparam logic [3:0] K_LPAREN = 4'd4;
  localparam logic [3:0] K_RPAREN = 4'd5;
  localparam logic [3:0] K_LBRACE = 4'd6;
  localparam logic [3:0] K_RBRACE = 4'd7;
  localparam logic [3:0] K_EQ     = 4'd8;
  localparam logic [3:0] K_ARROW  = 4'd9;
  localparam logic [3:0] K_ERR    = 4'd10;

  localparam logic [1:0] E_NONE     = 2'd0;
  localparam logic [1:0] E_OVERFLOW = 2'd1;
  localparam logic [1:0] E_CHAR     = 2'd2;
  localparam logic [1:0] E_LONG     = 2'd3;

  typedef struct packed {
    logic [3:0]      kind;
    logic [1:0]      code;
    logic [TOKW-1:0] line;
    logic [TOKW-1:0] start;
    logic [TOKW-1:0] length;
    logic [VALW-1:0] value;
    logic            last;
  } token_t;

  typedef struct packed {
    logic [1:0] count;
    token_t     tok0;
    token_t     tok1;
  } push_t;

endpackage

// File: rtl/core/sct_front.sv
module sct_front import sct_pkg::*; #(
  parameter int MAX_SOURCE = 1048576,
  parameter int PW = 21
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] source_byte,
  output push_t      push
);

  localparam logic [2:0] M_IDLE    = 3'd0;
  localparam logic [2:0] M_COMMENT = 3'd1;
  localparam logic [2:0] M_INT     = 3'd2;
  localparam logic [2:0] M_IDENT   = 3'd3;
  localparam logic [2:0] M_BANG    = 3'd4;
  localparam logic [2:0] M_MINUS   = 3'd5;
  localparam logic [2:0] M_HALT    = 3'd6;

  logic [2:0]      mode, mode_next;
  logic [PW-1:0]   pos, pos_next;
  logic [PW-1:0]   line, line_next;
  logic [PW-1:0]   pstart, pstart_next;
  logic [PW-1:0]   pline, pline_next;
  logic [VALW-1:0] acc, acc_next;

  logic [2:0]      f_mode;
  logic [PW-1:0]   f_pos, f_line, f_pstart, f_pline;
  logic [VALW-1:0] f_acc;
  logic            f_valid;
  token_t          f_tok;

  logic            p_valid, use_fresh;
  token_t          p_tok;

  logic            c_digit, c_alpha, c_word;
  logic [3:0]      digit;
  logic [VALW+3:0] acc_mac;

  function automatic token_t make_tok(logic [3:0] kind, logic [1:0] code,
                                      logic [PW-1:0] ln, logic [PW-1:0] st,
                                      logic [PW-1:0] len, logic [VALW-1:0] val);
    token_t t;
    t.kind   = kind;
    t.code   = code;
    t.line   = ln[TOKW-1:0];
    t.start  = st[TOKW-1:0];
    t.length = len[TOKW-1:0];
    t.value  = val;
    t.last   = 1'b0;
    return t;
  endfunction

  assign c_digit = source_byte inside {[8'h30:8'h39]};
  assign c_alpha = source_byte inside {[8'h41:8'h5a], [8'h61:8'h7a]};
  assign c_word  = c_digit || c_alpha || (source_byte == 8'h5f);
  assign digit   = source_byte[3:0];
  assign acc_mac = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {{VALW{1'b0}}, digit};

  // byte with no token pending
  always_comb begin
    f_mode   = M_IDLE;
    f_pos    = pos + PW'(1);
    f_line   = line;
    f_pstart = pstart;
    f_pline  = pline;
    f_acc    = acc;
    f_valid  = 1'b0;
    f_tok    = make_tok(K_ERR, E_CHAR, line, pos, '0, '0);
    case (source_byte)
      8'h00: begin
        f_valid = 1'b1;
        f_tok   = make_tok(K_EOF, E_NONE, line, pos, '0, '0);
        f_mode  = M_HALT;
        f_pos   = pos;
      end
      8'h0a: begin
        f_valid = 1'b1;
        f_tok   = make_tok(K_NL, E_NONE, line, pos, PW'(1), '0);
        f_line  = line + PW'(1);
      end
      8'h20, 8'h09, 8'h0d: begin
      end
      8'h23: f_mode = M_COMMENT;
      8'h28, 8'h29, 8'h7b, 8'h7d, 8'h3d: begin
        f_valid = 1'b1;
        case (source_byte)
          8'h28:   f_tok = make_tok(K_LPAREN, E_NONE, line, pos, PW'(1), '0);
          8'h29:   f_tok = make_tok(K_RPAREN, E_NONE, line, pos, PW'(1), '0);
          8'h7b:   f_tok = make_tok(K_LBRACE, E_NONE, line, pos, PW'(1), '0);
          8'h7d:   f_tok = make_tok(K_RBRACE, E_NONE, line, pos, PW'(1), '0);
          default: f_tok = make_tok(K_EQ, E_NONE, line, pos, PW'(1), '0);
        endcase
      end
      default: begin
        if (c_word || source_byte == 8'h2d) begin
          f_pstart = pos;
          f_pline  = line;
          if (c_digit) begin
            f_mode = M_INT;
            f_acc  = {{(VALW-4){1'b0}}, digit};
          end else if (source_byte == 8'h2d) begin
            f_mode = M_MINUS;
          end else begin
            f_mode = M_IDENT;
          end
        end else begin
          f_valid = 1'b1;
          f_mode  = M_HALT;
          f_pos   = pos;
        end
      end
    endcase
  end

  always_comb begin
    mode_next   = mode;
    pos_next    = pos;
    line_next   = line;
    pstart_next = pstart;
    pline_next  = pline;
    acc_next    = acc;
    p_valid     = 1'b0;
    p_tok       = make_tok(K_ERR, E_CHAR, line, pos, '0, '0);
    use_fresh   = 1'b0;
    if (mode == M_HALT) begin
    end else if (source_byte != 8'h00 && pos >= PW'(MAX_SOURCE)) begin
      p_valid   = 1'b1;
      p_tok     = make_tok(K_ERR, E_LONG, line, pos, '0, '0);
      mode_next = M_HALT;
    end else begin
      case (mode)
        M_IDLE: use_fresh = 1'b1;
        M_COMMENT: begin
          if (source_byte == 8'h0a || source_byte == 8'h00) begin
            use_fresh = 1'b1;
          end else begin
            pos_next = pos + PW'(1);
          end
        end
        M_INT: begin
          if (c_digit) begin
            if (acc_mac[VALW+3:VALW] != 4'd0) begin
              p_valid   = 1'b1;
              p_tok     = make_tok(K_ERR, E_OVERFLOW, line, pstart, '0, '0);
              mode_next = M_HALT;
            end else begin
              acc_next = acc_mac[VALW-1:0];
              pos_next = pos + PW'(1);
            end
          end else begin
            p_valid   = 1'b1;
            p_tok     = make_tok(K_INT, E_NONE, pline, pstart, pos - pstart, acc);
            use_fresh = 1'b1;
          end
        end
        M_IDENT: begin
          if (c_word) begin
            pos_next = pos + PW'(1);
          end else if (source_byte == 8'h21) begin
            mode_next = M_BANG;
            pos_next  = pos + PW'(1);
          end else begin
            p_valid   = 1'b1;
            p_tok     = make_tok(K_IDENT, E_NONE, pline, pstart, pos - pstart, '0);
            use_fresh = 1'b1;
          end
        end
        M_BANG: begin
          p_valid = 1'b1;
          if (source_byte == 8'h3d) begin
            p_tok = make_tok(K_IDENT, E_NONE, pline, pstart,
                             pos - PW'(1) - pstart, '0);
          end else begin
            p_tok     = make_tok(K_IDENT, E_NONE, pline, pstart, pos - pstart, '0);
            use_fresh = 1'b1;
          end
        end
        M_MINUS: begin
          if (source_byte == 8'h3e) begin
            p_valid   = 1'b1;
            p_tok     = make_tok(K_ARROW, E_NONE, pline, pstart, PW'(2), '0);
            mode_next = M_IDLE;
            pos_next  = pos + PW'(1);
          end else begin
            p_valid   = 1'b1;
            p_tok     = make_tok(K_ERR, E_CHAR, line, pstart, '0, '0);
            mode_next = M_HALT;
          end
        end
        default: mode_next = M_HALT;
      endcase
      if (use_fresh) begin
        mode_next   = f_mode;
        pos_next    = f_pos;
        line_next   = f_line;
        pstart_next = f_pstart;
        pline_next  = f_pline;
        acc_next    = f_acc;
      end
    end
  end

  // bang followed by equals: error at the bang after the ident
  logic   bang_err;
  token_t second_tok;
  logic   second_valid;

  assign bang_err     = (mode == M_BANG) && p_valid && !use_fresh && (p_tok.kind == K_IDENT);
  assign second_valid = bang_err || (use_fresh && f_valid);

  always_comb begin
    second_tok = f_tok;
    if (bang_err) begin
      second_tok = make_tok(K_ERR, E_CHAR, line, pos - PW'(1), '0, '0);
    end
  end

  always_comb begin
    push.count = 2'd0;
    push.tok0  = second_tok;
    push.tok1  = second_tok;
    if (accept) begin
      if (p_valid) begin
        push.tok0 = p_tok;
        if (second_valid) begin
          push.count     = 2'd2;
          push.tok1.last = 1'b1;
        end else begin
          push.count     = 2'd1;
          push.tok0.last = 1'b1;
        end
      end else if (second_valid) begin
        push.count     = 2'd1;
        push.tok0.last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= M_IDLE;
      pos    <= '0;
      line   <= PW'(1);
      pstart <= '0;
      pline  <= PW'(1);
      acc    <= '0;
    end else if (accept) begin
      mode   <= bang_err ? M_HALT : mode_next;
      pos    <= pos_next;
      line   <= line_next;
      pstart <= pstart_next;
      pline  <= pline_next;
      acc    <= acc_next;
    end
  end

endmodule

// File: rtl/core/sct_queue.sv
module sct_queue import sct_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  push_t  push,
  output logic   room,
  output logic   out_valid,
  input  logic   out_stall,
  output token_t head
);

  token_t           q [QDEPTH];
  logic [QAW-1:0]   wptr, rptr;
  logic [QCW-1:0]   count;
  logic             pop;

  assign room      = count <= QCW'(QDEPTH - 2);
  assign out_valid = count != '0;
  assign pop       = out_valid && !out_stall;
  assign head      = q[rptr];

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      q[wptr] <= push.tok0;
    end
    if (push.count == 2'd2) begin
      q[wptr + QAW'(1)] <= push.tok1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + QAW'(push.count);
      rptr  <= rptr + QAW'(pop);
      count <= count + QCW'(push.count) - QCW'(pop);
    end
  end

endmodule

// File: rtl/core/source_char_tokenizer.sv
// a token is written into the token queue when the byte that closes it is taken
// throughput: one byte per cycle while the token queue has room, else in_stall is raised;
// a byte that yields two tokens writes both into the four-entry token queue at once
// the lexer state update and the integer shift-add lie on the combinational path of each byte step
// reset: synchronous, active high; clears the lexer state and empties the queue
module source_char_tokenizer import sct_pkg::*; #(
  parameter int MAX_SOURCE = 1048576
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  source_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  token_kind,
  output logic [1:0]  error_code,
  output logic [20:0] token_line,
  output logic [20:0] token_start,
  output logic [20:0] token_length,
  output logic [62:0] int_value,
  output logic        run_last
);

  localparam int PW = ($clog2(MAX_SOURCE + 2) > TOKW) ? $clog2(MAX_SOURCE + 2) : TOKW;

  logic   room, accept;
  push_t  push;
  token_t head;

  assign in_stall = !room;
  assign accept   = in_valid && room;

  sct_front #(
    .MAX_SOURCE(MAX_SOURCE),
    .PW(PW)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .source_byte(source_byte),
    .push(push)
  );

  sct_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .room(room),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .head(head)
  );

  assign token_kind   = head.kind;
  assign error_code   = head.code;
  assign token_line   = head.line;
  assign token_start  = head.start;
  assign token_length = head.length;
  assign int_value    = head.value;
  assign run_last     = head.last;

endmodule

// File: tb/tb_source_char_tokenizer.sv
module tb_source_char_tokenizer;
  timeunit 1ns;
  timeprecision 1ps;
  import sct_pkg::*;

  localparam int MAX_SRC = 960;
  localparam int STUCK_LIMIT = 400;
  localparam int RANDOM_BYTES = 860;
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_NL = 8'h0a;
  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [63:0] VAL_MAX = 64'h7fff_ffff_ffff_ffff;

  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_COMMENT, SCAN_INT, SCAN_IDENT, SCAN_BANG, SCAN_MINUS, SCAN_HALT
  } scan_mode_e;

  typedef struct {
    logic [7:0] ch;
    bit         pinned;
    token_t     tok;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] source_byte = 8'h00;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [3:0] token_kind;
  logic [1:0] error_code;
  logic [20:0] token_line;
  logic [20:0] token_start;
  logic [20:0] token_length;
  logic [62:0] int_value;
  logic run_last;

  // predictor state
  scan_mode_e lx_mode = SCAN_IDLE;
  logic [31:0] at_pos = 0;
  logic [31:0] cur_line = 1;
  logic [31:0] tok_begin = 0;
  logic [31:0] tok_line = 1;
  logic [63:0] num_acc = 0;

  token_t step_tokens[$];
  token_t tokens_due[$];
  logic [7:0] chunk_q[$];
  dir_row_t dir_rows[$];

  bit row_pinned = 1'b0;
  token_t row_token = '0;
  bit calm = 1'b0;
  int unsigned bytes_taken = 0;
  int unsigned tokens_taken = 0;
  int unsigned rx_seen = 0;
  int unsigned rx_wait = 0;
  int unsigned stuck_cycles = 0;
  int unsigned bad_count = 0;
  bit moved;
  bit match;
  token_t got;
  token_t want;

  source_char_tokenizer #(.MAX_SOURCE(MAX_SRC)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .source_byte(source_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .token_kind(token_kind),
    .error_code(error_code),
    .token_line(token_line),
    .token_start(token_start),
    .token_length(token_length),
    .int_value(int_value),
    .run_last(run_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic bit is_dig(logic [7:0] ch);
    return ch >= "0" && ch <= "9";
  endfunction

  function automatic bit is_alpha(logic [7:0] ch);
    return (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z");
  endfunction

  function automatic bit is_word(logic [7:0] ch);
    return is_alpha(ch) || is_dig(ch) || ch == "_";
  endfunction

  function automatic void put_tok(logic [3:0] k, logic [1:0] ec, logic [31:0] ln,
                                  logic [31:0] st, logic [31:0] len, logic [63:0] v);
    token_t t;
    t.kind = k;
    t.code = ec;
    t.line = ln[20:0];
    t.start = st[20:0];
    t.length = len[20:0];
    t.value = v[62:0];
    t.last = 1'b0;
    step_tokens.push_back(t);
  endfunction

  function automatic void halt_err(logic [1:0] ec, logic [31:0] where);
    put_tok(K_ERR, ec, cur_line, where, 0, 0);
    lx_mode = SCAN_HALT;
  endfunction

  // a byte seen with nothing pending
  function automatic void lex_fresh(logic [7:0] ch);
    logic [3:0] k;
    if (ch == CH_NUL) begin
      put_tok(K_EOF, E_NONE, cur_line, at_pos, 0, 0);
      lx_mode = SCAN_HALT;
    end else if (ch == CH_NL) begin
      put_tok(K_NL, E_NONE, cur_line, at_pos, 1, 0);
      cur_line++;
      at_pos++;
    end else if (ch == " " || ch == CH_TAB || ch == CH_CR) begin
      at_pos++;
    end else if (ch == "#") begin
      lx_mode = SCAN_COMMENT;
      at_pos++;
    end else if (is_word(ch) || ch == "-") begin
      tok_begin = at_pos;
      tok_line = cur_line;
      if (is_dig(ch)) begin
        lx_mode = SCAN_INT;
        num_acc = ch - "0";
      end else begin
        lx_mode = (ch == "-") ? SCAN_MINUS : SCAN_IDENT;
      end
      at_pos++;
    end else begin
      case (ch)
        "(": k = K_LPAREN;
        ")": k = K_RPAREN;
        "{": k = K_LBRACE;
        "}": k = K_RBRACE;
        "=": k = K_EQ;
        default: k = K_ERR;
      endcase
      if (k == K_ERR) begin
        halt_err(E_CHAR, at_pos);
      end else begin
        put_tok(k, E_NONE, cur_line, at_pos, 1, 0);
        at_pos++;
      end
    end
  endfunction

  function automatic void lex_step(logic [7:0] ch);
    logic [63:0] d;
    step_tokens.delete();
    if (lx_mode == SCAN_HALT) return;
    if (ch != CH_NUL && at_pos >= MAX_SRC) begin
      halt_err(E_LONG, at_pos);
    end else begin
      case (lx_mode)
        SCAN_COMMENT: begin
          if (ch == CH_NL || ch == CH_NUL) begin
            lx_mode = SCAN_IDLE;
            lex_fresh(ch);
          end else begin
            at_pos++;
          end
        end
        SCAN_INT: begin
          if (is_dig(ch)) begin
            d = ch - "0";
            if (num_acc > (VAL_MAX - d) / 10) begin
              halt_err(E_OVERFLOW, tok_begin);
            end else begin
              num_acc = num_acc * 10 + d;
              at_pos++;
            end
          end else begin
            put_tok(K_INT, E_NONE, tok_line, tok_begin, at_pos - tok_begin, num_acc);
            lx_mode = SCAN_IDLE;
            lex_fresh(ch);
          end
        end
        SCAN_IDENT: begin
          if (is_word(ch)) begin
            at_pos++;
          end else if (ch == "!") begin
            lx_mode = SCAN_BANG;
            at_pos++;
          end else begin
            put_tok(K_IDENT, E_NONE, tok_line, tok_begin, at_pos - tok_begin, 0);
            lx_mode = SCAN_IDLE;
            lex_fresh(ch);
          end
        end
        SCAN_BANG: begin
          if (ch == "=") begin
            put_tok(K_IDENT, E_NONE, tok_line, tok_begin, at_pos - 1 - tok_begin, 0);
            halt_err(E_CHAR, at_pos - 1);
          end else begin
            put_tok(K_IDENT, E_NONE, tok_line, tok_begin, at_pos - tok_begin, 0);
            lx_mode = SCAN_IDLE;
            lex_fresh(ch);
          end
        end
        SCAN_MINUS: begin
          if (ch == ">") begin
            put_tok(K_ARROW, E_NONE, tok_line, tok_begin, 2, 0);
            lx_mode = SCAN_IDLE;
            at_pos++;
          end else begin
            halt_err(E_CHAR, tok_begin);
          end
        end
        default: lex_fresh(ch);
      endcase
    end
    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
  endfunction

  function automatic bit field_ok(string nm, logic [62:0] w, logic [62:0] g);
    if (w !== g) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, nm, w, g);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic int unsigned pause_len();
    if (calm || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 13);
  endfunction

  // token and request checking, watchdog
  always @(posedge clk) begin
    if (!rst) begin
      moved = 1'b0;
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        tokens_taken++;
        got.kind = token_kind;
        got.code = error_code;
        got.line = token_line;
        got.start = token_start;
        got.length = token_length;
        got.value = int_value;
        got.last = run_last;
        if (tokens_due.size() == 0) begin
          $display("%0t: token with none expected, actual kind %0d start %0d",
                   $time, token_kind, token_start);
          bad_count++;
        end else begin
          want = tokens_due.pop_front();
          match = field_ok("token_kind", want.kind, got.kind)
                & field_ok("error_code", want.code, got.code)
                & field_ok("token_line", want.line, got.line)
                & field_ok("token_start", want.start, got.start)
                & field_ok("token_length", want.length, got.length)
                & field_ok("int_value", want.value, got.value)
                & field_ok("run_last", want.last, got.last);
          if (!match) bad_count++;
        end
      end
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        bytes_taken++;
        lex_step(source_byte);
        if (row_pinned) tokens_due.push_back(row_token);
        else foreach (step_tokens[i]) tokens_due.push_back(step_tokens[i]);
      end
      if (moved) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
          $display("Regression FAIL");
          $finish;
        end
      end
    end
  end

  // token sink back-pressure
  always @(negedge clk) begin
    if (tokens_taken != rx_seen) begin
      rx_seen = tokens_taken;
      rx_wait = pause_len();
    end
    out_stall <= (rx_wait != 0);
    if (rx_wait != 0) rx_wait--;
  end

  task automatic send_byte(logic [7:0] ch, bit pin, token_t ptok);
    int unsigned gap;
    int unsigned seen;
    gap = pause_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    source_byte <= ch;
    row_pinned <= pin;
    row_token <= ptok;
    seen = bytes_taken;
    do @(negedge clk); while (bytes_taken == seen);
  endtask

  task automatic flush_chunk();
    while (chunk_q.size() != 0) send_byte(chunk_q.pop_front(), 1'b0, '0);
  endtask

  task automatic drain_tokens();
    in_valid <= 1'b0;
    do @(negedge clk); while (tokens_due.size() != 0);
  endtask

  function automatic void push_str(string s);
    for (int i = 0; i < s.len(); i++) chunk_q.push_back(s[i]);
  endfunction

  function automatic void push_comment();
    logic [7:0] v;
    int unsigned n;
    n = $urandom_range(0, 10);
    chunk_q.push_back("#");
    repeat (n) begin
      do v = 8'($urandom_range(1, 255)); while (v == CH_NL);
      chunk_q.push_back(v);
    end
    chunk_q.push_back(CH_NL);
  endfunction

  function automatic logic [7:0] word_char(bit head);
    case ($urandom_range(head ? 0 : 0, head ? 2 : 3))
      0: return 8'("a" + $urandom_range(0, 25));
      1: return 8'("A" + $urandom_range(0, 25));
      2: return "_";
      default: return 8'("0" + $urandom_range(0, 9));
    endcase
  endfunction

  // closes a pending ident or int; no '=' right after a bang
  function automatic void push_sep(bit after_bang);
    case ($urandom_range(0, 10))
      0: chunk_q.push_back(" ");
      1: chunk_q.push_back(CH_TAB);
      2: chunk_q.push_back(CH_CR);
      3: chunk_q.push_back(CH_NL);
      4: chunk_q.push_back("(");
      5: chunk_q.push_back(")");
      6: chunk_q.push_back("{");
      7: chunk_q.push_back("}");
      8: chunk_q.push_back(after_bang ? ")" : "=");
      9: push_str("->");
      default: push_comment();
    endcase
  endfunction

  function automatic void add_chunk();
    int unsigned n;
    bit bang;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        chunk_q.push_back(word_char(1'b1));
        n = $urandom_range(0, 7);
        repeat (n) chunk_q.push_back(word_char(1'b0));
        bang = ($urandom_range(0, 3) == 0);
        if (bang) chunk_q.push_back("!");
        push_sep(bang);
      end
      3, 4: begin
        if ($urandom_range(0, 7) == 0) begin
          push_str("9223372036854775807");
        end else begin
          n = $urandom_range(1, 19);
          chunk_q.push_back(8'("0" + ((n == 19) ? $urandom_range(0, 8)
                                                : $urandom_range(0, 9))));
          repeat (n - 1) chunk_q.push_back(8'("0" + $urandom_range(0, 9)));
        end
        push_sep(1'b0);
      end
      5: begin
        case ($urandom_range(0, 4))
          0: chunk_q.push_back("(");
          1: chunk_q.push_back(")");
          2: chunk_q.push_back("{");
          3: chunk_q.push_back("}");
          default: chunk_q.push_back("=");
        endcase
      end
      6: push_str("->");
      7: begin
        n = $urandom_range(1, 3);
        repeat (n) begin
          case ($urandom_range(0, 3))
            0: chunk_q.push_back(" ");
            1: chunk_q.push_back(CH_TAB);
            2: chunk_q.push_back(CH_CR);
            default: chunk_q.push_back(CH_NL);
          endcase
        end
      end
      8: push_comment();
      default: chunk_q.push_back(CH_NL);
    endcase
  endfunction

  function automatic void add_row(logic [7:0] ch);
    dir_row_t r;
    r.ch = ch;
    r.pinned = 1'b0;
    r.tok = '0;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_pinned(logic [7:0] ch, logic [3:0] k, logic [31:0] ln,
                                     logic [31:0] st, logic [31:0] len);
    dir_row_t r;
    r.ch = ch;
    r.pinned = 1'b1;
    r.tok = '0;
    r.tok.kind = k;
    r.tok.code = E_NONE;
    r.tok.line = ln[20:0];
    r.tok.start = st[20:0];
    r.tok.length = len[20:0];
    r.tok.last = 1'b1;
    dir_rows.push_back(r);
  endfunction

  initial begin
    int unsigned rand_sent;
    int unsigned seg_mark;
    int unsigned seg_no;
    logic [7:0] v;

    add_pinned("(", K_LPAREN, 1, 0, 1);
    add_pinned(")", K_RPAREN, 1, 1, 1);
    add_pinned("{", K_LBRACE, 1, 2, 1);
    add_pinned("}", K_RBRACE, 1, 3, 1);
    add_pinned("=", K_EQ, 1, 4, 1);
    add_row("-");
    add_pinned(">", K_ARROW, 1, 5, 2);
    add_pinned(CH_NL, K_NL, 1, 7, 1);
    add_row("_");
    add_row("z");
    add_row("9");
    add_row("!");
    add_row("(");
    add_row("0");
    add_row(")");
    add_row("#");
    add_row(8'hff);
    add_pinned(CH_NL, K_NL, 2, 17, 1);
    add_row(" ");
    add_row(CH_TAB);
    add_row(CH_CR);
    add_row("Z");
    add_row("a");
    add_row(CH_NL);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_byte(dir_rows[i].ch, dir_rows[i].pinned, dir_rows[i].tok);

    // well-formed source with random content
    rand_sent = 0;
    seg_mark = 0;
    seg_no = 0;
    while (rand_sent < RANDOM_BYTES) begin
      if (rand_sent >= seg_mark) begin
        seg_no++;
        seg_mark += 120;
        calm = (seg_no == 3) || ($urandom_range(0, 3) == 0);
        if (seg_no == 4 || $urandom_range(0, 2) == 0) drain_tokens();
      end
      add_chunk();
      rand_sent += chunk_q.size();
      flush_chunk();
    end
    calm = 1'b0;

    // one way of ending the source, since the block halts until reset
    case ($urandom_range(0, 7))
      0: begin
        push_str("42");
        chunk_q.push_back(CH_NUL);
      end
      1: begin
        push_str("# x");
        chunk_q.push_back(CH_NUL);
      end
      2: push_str("-x");
      3: begin
        chunk_q.push_back("-");
        chunk_q.push_back(CH_NUL);
      end
      4: push_str("ab!=");
      5: begin
        do v = 8'($urandom_range(1, 255));
        while (is_word(v) || v == "-" || v == " " || v == CH_TAB || v == CH_CR ||
               v == CH_NL || v == "#" || v == "(" || v == ")" || v == "{" ||
               v == "}" || v == "=");
        push_str("7");
        chunk_q.push_back(v);
      end
      6: push_str("9223372036854775808 ");
      default: begin
        while (lx_mode != SCAN_HALT) begin
          add_chunk();
          flush_chunk();
        end
      end
    endcase
    flush_chunk();

    // halted: everything ignored
    chunk_q.push_back(8'h80);
    repeat (24) chunk_q.push_back(8'($urandom_range(0, 255)));
    flush_chunk();

    drain_tokens();
    repeat (16) @(negedge clk);
    if (bad_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
